// File: hw/rtl/tcpa_pkg.sv
package tcpa_pkg;

    // field widths
    localparam int OP_W     = 1;
    localparam int TYPE_W   = 2;
    localparam int SIZE_W   = 17;
    localparam int ADDR_W   = 20;
    localparam int STATUS_W = 2;

    // pool geometry
    localparam int TYPE_COUNT = 1 << TYPE_W;
    localparam int GRAN_SHIFT = 4;
    localparam int GRAN_BYTES = 1 << GRAN_SHIFT;
    localparam int GIDX_W     = ADDR_W - GRAN_SHIFT;
    localparam int LINK_W     = GIDX_W + 1;
    localparam int LINK_DEPTH = 1 << GIDX_W;
    localparam int SLAB_SHIFT = 16;
    localparam int SLAB_BYTES = 1 << SLAB_SHIFT;
    localparam int SLAB_COUNT = 16;
    localparam int SLABS_W    = 5;
    localparam int BUMP_W     = 21;
    localparam int CHUNK_W    = SIZE_W + 1;
    localparam int GRANS_W    = CHUNK_W - GRAN_SHIFT;

    // operations
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SLAB  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_TOO_BIG  = 2'd2;

    // one link store entry: valid bit plus next granule index
    typedef struct packed {
        logic              valid;
        logic [GIDX_W-1:0] next;
    } t_link;

endpackage

// File: hw/rtl/tcpa_req_if.sv
interface tcpa_req_if;
    import tcpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [TYPE_W-1:0]   obj_type;
    logic [SIZE_W-1:0]   size_bytes;
    logic [ADDR_W-1:0]   chunk_address;

    modport source (
        output valid, operation, obj_type, size_bytes, chunk_address,
        input  ready
    );

    modport sink (
        input  valid, operation, obj_type, size_bytes, chunk_address,
        output ready
    );

endinterface

// File: hw/rtl/tcpa_rsp_if.sv
interface tcpa_rsp_if;
    import tcpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, result_address, status,
        input  ready
    );

    modport sink (
        input  valid, result_address, status,
        output ready
    );

endinterface

// File: hw/rtl/tcpa_ram.sv
module tcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/typed_chunk_pool_allocator_core.sv
// typed chunk pool allocator: four per-type pools, each a lifo free list
// plus a bump region carved from 64 KB slabs of a fixed supply of sixteen
//
// request channel i_req carries operation, obj_type, size_bytes and
// chunk_address; response channel o_rsp carries result_address and status,
// exactly one response per request, in request order
//
// timing: an item is taken at the transfer, where the link store read is
// issued, and finished in the execute step, when the registered link is
// back and the head, bump region and link store are updated; the response
// is valid in the cycle after the execute step completes; a new request is
// not taken before that, since the request channel is ready only when idle
//
// a stalled receiver holds the response in the output register; a new
// request is still taken and read, then waits in the execute step until
// the output register frees up
//
// reset clears all heads, bump regions and the slab count; the link store
// is not cleared, since a link is only used after a free has written it
module typed_chunk_pool_allocator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcpa_req_if.sink   i_req,
    tcpa_rsp_if.source o_rsp
);
    import tcpa_pkg::*;

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;

    // request held for the execute step
    logic [OP_W-1:0]   r_op;
    logic [TYPE_W-1:0] r_type;
    logic [SIZE_W-1:0] r_size;
    logic [GIDX_W-1:0] r_gidx;

    // per-pool state
    logic              r_head_valid [TYPE_COUNT];
    logic [GIDX_W-1:0] r_head       [TYPE_COUNT];
    logic [BUMP_W-1:0] r_cursor     [TYPE_COUNT];
    logic [BUMP_W-1:0] r_end        [TYPE_COUNT];
    logic [SLABS_W-1:0] r_slabs_used;

    // output register
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [STATUS_W-1:0] r_out_status;

    // link store port signals
    logic              ram_we;
    logic [GIDX_W-1:0] ram_waddr;
    t_link             ram_wdata;
    logic              ram_re;
    logic [GIDX_W-1:0] ram_raddr;
    t_link             ram_rdata;

    logic in_xfer;
    logic exec_done;

    // execute-step datapath
    logic [GRANS_W-1:0] granules;
    logic [CHUNK_W-1:0] chunk;
    logic               too_big;
    logic               no_room;
    logic               exhausted;
    logic [BUMP_W-1:0]  slab_base;
    logic [BUMP_W-1:0]  alloc_base;
    logic [ADDR_W-1:0]  res_addr;
    logic [STATUS_W-1:0] res_status;

    assign i_req.ready = (r_state == ST_IDLE);
    assign in_xfer     = i_req.valid && i_req.ready;

    // execute finishes once the output register can take the response
    assign exec_done = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);

    // read the head link of the requested pool at the transfer
    assign ram_re    = in_xfer;
    assign ram_raddr = r_head[i_req.obj_type];

    // a free pushes the chunk: its link points at the old head
    assign ram_we          = exec_done && (r_op == OP_FREE);
    assign ram_waddr       = r_gidx;
    assign ram_wdata.valid = r_head_valid[r_type];
    assign ram_wdata.next  = r_head[r_type];

    tcpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // size rounded up to whole granules, zero size counts as one granule
    always_comb begin
        granules = GRANS_W'((CHUNK_W'(r_size) + CHUNK_W'(GRAN_BYTES - 1)) >> GRAN_SHIFT);
        if (granules == '0) begin
            granules = GRANS_W'(1);
        end
        chunk = {granules, GRAN_SHIFT'(0)};
    end

    assign too_big   = chunk > CHUNK_W'(SLAB_BYTES);
    assign no_room   = (r_cursor[r_type] > r_end[r_type]) ||
                       ((r_end[r_type] - r_cursor[r_type]) < BUMP_W'(chunk));
    assign exhausted = r_slabs_used >= SLABS_W'(SLAB_COUNT);
    assign slab_base = BUMP_W'(r_slabs_used) << SLAB_SHIFT;
    assign alloc_base = no_room ? slab_base : r_cursor[r_type];

    // response of the item in the execute step
    always_comb begin
        res_addr   = '0;
        res_status = STAT_OK;
        if (r_op == OP_ALLOC) begin
            priority if (r_head_valid[r_type]) begin
                res_addr = {r_head[r_type], GRAN_SHIFT'(0)};
            end else if (too_big) begin
                res_status = STAT_TOO_BIG;
            end else if (no_room && exhausted) begin
                res_status = STAT_NO_SLAB;
            end else begin
                res_addr = alloc_base[ADDR_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control and pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_slabs_used <= '0;
            for (int k = 0; k < TYPE_COUNT; k++) begin
                r_head_valid[k] <= 1'b0;
                r_head[k]       <= '0;
                r_cursor[k]     <= '0;
                r_end[k]        <= '0;
            end
        end else begin
            r_state <= n_state;
            if (exec_done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            if (exec_done) begin
                if (r_op == OP_FREE) begin
                    r_head_valid[r_type] <= 1'b1;
                    r_head[r_type]       <= r_gidx;
                end else if (r_head_valid[r_type]) begin
                    // pop: the next head comes from the registered link
                    r_head_valid[r_type] <= ram_rdata.valid;
                    r_head[r_type]       <= ram_rdata.valid ? ram_rdata.next : '0;
                end else if (!too_big && !(no_room && exhausted)) begin
                    if (no_room) begin
                        // abandon the rest of the old slab
                        r_end[r_type] <= slab_base + BUMP_W'(SLAB_BYTES);
                        r_slabs_used  <= r_slabs_used + SLABS_W'(1);
                    end
                    r_cursor[r_type] <= alloc_base + BUMP_W'(chunk);
                end
            end
        end
    end

    // request capture and response payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= i_req.operation;
            r_type <= i_req.obj_type;
            r_size <= i_req.size_bytes;
            r_gidx <= i_req.chunk_address[ADDR_W-1:GRAN_SHIFT];
        end
        if (exec_done) begin
            r_out_addr   <= res_addr;
            r_out_status <= res_status;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_address = r_out_addr;
    assign o_rsp.status         = r_out_status;

    // a taken request always moves to the execute step
    a_xfer_to_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_EXEC))
        else $error("request transfer did not start execute step");

    // a failed allocation never hands out an address
    a_fail_addr_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != STAT_OK)) |-> (o_rsp.result_address == '0))
        else $error("nonzero address with failing status");

    // the slab supply is never overdrawn
    a_slabs_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slabs_used <= SLABS_W'(SLAB_COUNT))
        else $error("slab count beyond supply");

    // the link store is written only when an item completes
    a_link_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready)))
        else $error("link store written outside completion");

    // a response that is stalled stays put
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(r_out_addr)
            && $stable(r_out_status)))
        else $error("stalled response changed");

    // the bump cursor never passes the end of its slab
    a_cursor_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> (r_cursor[r_type] <= r_end[r_type]))
        else $error("bump cursor past slab end");

endmodule
